### rtl/core/pinned_lru_contact_table_assert.svh
// Assertion macros for the contact table RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef PINNED_LRU_CONTACT_TABLE_ASSERT_SVH
`define PINNED_LRU_CONTACT_TABLE_ASSERT_SVH

// Same-cycle implication
`define PLCT_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("contact table assertion failed");

// Next-cycle implication
`define PLCT_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("contact table assertion failed");

`endif

### rtl/core/plct_pkg.sv
// Package for the contact table: transaction layouts, entry layout, codes.
// No dependencies.
`timescale 1ns / 1ps

package plct_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam logic [5:0] LIST_CAP = 6'd32;
  // Last-heard time that can never be picked for replacement
  localparam logic [31:0] HTIME_CEIL = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_UPSERT = 3'd0,
    OP_FIND   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_TOGGLE = 3'd3,
    OP_READ   = 3'd4,
    OP_LIST   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_ALL_FAV = 2'd2
  } status_t;

  // Input transaction, lowest field in the lowest bits
  typedef struct packed {
    logic [1:0]        pad;
    logic [5:0]        max_count;
    logic [4:0]        slot;
    logic [31:0]       heard_time;
    logic signed [7:0] snr_in;
    logic signed [7:0] rssi_in;
    logic [7:0]        node_type;
    logic [31:0]       node_id;
    logic [2:0]        op;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [1:0]        pad;
    logic [5:0]        match_count;
    logic              out_favorite;
    logic [31:0]       out_time;
    logic signed [7:0] out_snr;
    logic signed [7:0] out_rssi;
    logic [7:0]        out_type;
    logic [31:0]       out_id;
    logic [4:0]        result_slot;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic      last;
    out_item_t d;
  } res_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [31:0]       id;
    logic [7:0]        ntype;
    logic signed [7:0] rssi;
    logic signed [7:0] snr;
    logic [31:0]       htime;
    logic              fav;
  } ent_t;

  function automatic ent_t mk_ent(in_item_t it, logic fav);
    ent_t e;
    e.id    = it.node_id;
    e.ntype = it.node_type;
    e.rssi  = it.rssi_in;
    e.snr   = it.snr_in;
    e.htime = it.heard_time;
    e.fav   = fav;
    return e;
  endfunction

  function automatic res_t mk_res(status_t st, logic [4:0] slot, logic last);
    res_t r;
    r               = '0;
    r.d.status      = st;
    r.d.result_slot = slot;
    r.last          = last;
    return r;
  endfunction

endpackage

### rtl/core/plct_mem.sv
// Entry memory: one write port, one read port, registered read data.
// Depends on plct_pkg (entry layout).
`timescale 1ns / 1ps

module plct_mem #(
  parameter int TABLE_DEPTH = plct_pkg::TABLE_DEPTH_DEF,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  plct_pkg::ent_t  wdata,
  input  logic            re,
  input  logic [IW-1:0]   raddr,
  output plct_pkg::ent_t  rdata
);

  plct_pkg::ent_t mem [TABLE_DEPTH];
  plct_pkg::ent_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/plct_ctrl.sv
// Sequencer of the contact table: scans, read-modify-write and result register.
// Depends on plct_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pinned_lru_contact_table_assert.svh"

module plct_ctrl #(
  parameter int TABLE_DEPTH = plct_pkg::TABLE_DEPTH_DEF,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  plct_pkg::in_item_t  in_item,
  output logic                out_tvalid,
  input  logic                out_tready,
  output plct_pkg::res_t      out_res,
  output logic                mem_we,
  output logic [IW-1:0]       mem_waddr,
  output plct_pkg::ent_t      mem_wdata,
  output logic                mem_re,
  output logic [IW-1:0]       mem_raddr,
  input  plct_pkg::ent_t      mem_rdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_OLD   = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_SLOT  = 7'b0010000,
    S_LIST  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  plct_pkg::in_item_t in_r, in_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      iss_r, iss_nxt;
  logic [CW-1:0]      end_r, end_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [31:0]        best_t_r, best_t_nxt;
  logic [IW-1:0]      best_idx_r, best_idx_nxt;
  logic               best_vld_r, best_vld_nxt;
  logic [IW-1:0]      pend_idx_r, pend_idx_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [5:0]         limit_r, limit_nxt;
  plct_pkg::res_t     res_r, res_nxt;
  logic               out_vld_r, out_vld_nxt;
  plct_pkg::res_t     out_r, out_nxt;

  logic               out_busy;
  logic               scan_done;
  logic               list_match;
  logic               list_stall;
  logic               slot_ok;
  logic [5:0]         lim_in;
  logic [5:0]         cnt_inc;

  assign out_busy   = out_vld_r && !out_tready;
  assign scan_done  = !rd_vld_r && (iss_r >= end_r);
  assign list_match = rd_vld_r && (mem_rdata.ntype == in_r.node_type);
  assign list_stall = (state_r == S_LIST) && list_match && pend_vld_r && out_busy;
  assign slot_ok    = (32'(in_item.slot) < 32'(fill_r)) &&
                      (32'(in_item.slot) < 32'(TABLE_DEPTH));
  assign lim_in     = (in_item.max_count > plct_pkg::LIST_CAP) ? plct_pkg::LIST_CAP
                                                               : in_item.max_count;
  assign cnt_inc    = cnt_r + 6'd1;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_res    = out_r;

  // Next-state logic
  always_comb begin
    state_nxt    = state_r;
    in_nxt       = in_r;
    fill_nxt     = fill_r;
    iss_nxt      = iss_r;
    end_nxt      = end_r;
    rd_vld_nxt   = rd_vld_r;
    rd_idx_nxt   = rd_idx_r;
    best_t_nxt   = best_t_r;
    best_idx_nxt = best_idx_r;
    best_vld_nxt = best_vld_r;
    pend_idx_nxt = pend_idx_r;
    pend_vld_nxt = pend_vld_r;
    cnt_nxt      = cnt_r;
    limit_nxt    = limit_r;
    res_nxt      = res_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    mem_we       = 1'b0;
    mem_waddr    = rd_idx_r;
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = iss_r[IW-1:0];

    // Read issue for every scanning state; one entry per cycle unless a list scan stalls
    if (state_r != S_IDLE && state_r != S_EMIT && !list_stall) begin
      if (iss_r < end_r) begin
        mem_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = iss_r[IW-1:0];
        iss_nxt    = iss_r + CW'(1);
      end else begin
        rd_vld_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        rd_vld_nxt = 1'b0;
        if (in_tvalid) begin
          in_nxt = in_item;
          unique case (in_item.op)
            plct_pkg::OP_UPSERT, plct_pkg::OP_FIND: begin
              state_nxt = S_LOOK;
              iss_nxt   = '0;
              end_nxt   = fill_r;
            end
            plct_pkg::OP_REMOVE: begin
              if (slot_ok) begin
                state_nxt = S_SHIFT;
                iss_nxt   = CW'(in_item.slot) + CW'(1);
                end_nxt   = fill_r;
              end else begin
                state_nxt = S_EMIT;
                res_nxt   = plct_pkg::mk_res(plct_pkg::ST_MISS, 5'd0, 1'b1);
              end
            end
            plct_pkg::OP_TOGGLE, plct_pkg::OP_READ: begin
              if (slot_ok) begin
                state_nxt = S_SLOT;
                iss_nxt   = CW'(in_item.slot);
                end_nxt   = CW'(in_item.slot) + CW'(1);
              end else begin
                state_nxt = S_EMIT;
                res_nxt   = plct_pkg::mk_res(plct_pkg::ST_MISS, 5'd0, 1'b1);
              end
            end
            plct_pkg::OP_LIST: begin
              limit_nxt    = lim_in;
              cnt_nxt      = '0;
              pend_vld_nxt = 1'b0;
              if (lim_in == 6'd0) begin
                state_nxt = S_EMIT;
                res_nxt   = plct_pkg::mk_res(plct_pkg::ST_OK, 5'd0, 1'b1);
              end else begin
                state_nxt = S_LIST;
                iss_nxt   = '0;
                end_nxt   = fill_r;
              end
            end
            default: begin
              state_nxt = S_EMIT;
              res_nxt   = plct_pkg::mk_res(plct_pkg::ST_MISS, 5'd0, 1'b1);
            end
          endcase
        end
      end

      // Id lookup over the filled entries
      S_LOOK: begin
        if (rd_vld_r && mem_rdata.id == in_r.node_id) begin
          if (in_r.op == plct_pkg::OP_UPSERT) begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx_r;
            mem_wdata = plct_pkg::mk_ent(in_r, mem_rdata.fav);
          end
          rd_vld_nxt = 1'b0;
          state_nxt  = S_EMIT;
          res_nxt    = plct_pkg::mk_res(plct_pkg::ST_OK, 5'(rd_idx_r), 1'b1);
        end else if (scan_done) begin
          if (in_r.op == plct_pkg::OP_FIND) begin
            state_nxt = S_EMIT;
            res_nxt   = plct_pkg::mk_res(plct_pkg::ST_MISS, 5'd0, 1'b1);
          end else if (32'(fill_r) < 32'(TABLE_DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = fill_r[IW-1:0];
            mem_wdata = plct_pkg::mk_ent(in_r, 1'b0);
            fill_nxt  = fill_r + CW'(1);
            state_nxt = S_EMIT;
            res_nxt   = plct_pkg::mk_res(plct_pkg::ST_OK, 5'(fill_r), 1'b1);
          end else begin
            state_nxt    = S_OLD;
            iss_nxt      = '0;
            end_nxt      = CW'(TABLE_DEPTH);
            best_t_nxt   = plct_pkg::HTIME_CEIL;
            best_vld_nxt = 1'b0;
          end
        end
      end

      // Oldest non-favorite search over the full table
      S_OLD: begin
        if (rd_vld_r) begin
          if (!mem_rdata.fav && mem_rdata.htime < best_t_r) begin
            best_t_nxt   = mem_rdata.htime;
            best_idx_nxt = rd_idx_r;
            best_vld_nxt = 1'b1;
          end
        end else if (scan_done) begin
          state_nxt = S_EMIT;
          if (best_vld_r) begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_r;
            mem_wdata = plct_pkg::mk_ent(in_r, 1'b0);
            res_nxt   = plct_pkg::mk_res(plct_pkg::ST_OK, 5'(best_idx_r), 1'b1);
          end else begin
            res_nxt   = plct_pkg::mk_res(plct_pkg::ST_ALL_FAV, 5'd0, 1'b1);
          end
        end
      end

      // Remove: copy each later entry one place down
      S_SHIFT: begin
        if (rd_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx_r - IW'(1);
          mem_wdata = mem_rdata;
        end else if (scan_done) begin
          fill_nxt  = fill_r - CW'(1);
          state_nxt = S_EMIT;
          res_nxt   = plct_pkg::mk_res(plct_pkg::ST_OK, in_r.slot, 1'b1);
        end
      end

      // Single entry read, or read-modify-write for toggle
      S_SLOT: begin
        if (rd_vld_r) begin
          rd_vld_nxt = 1'b0;
          state_nxt  = S_EMIT;
          res_nxt    = plct_pkg::mk_res(plct_pkg::ST_OK, in_r.slot, 1'b1);
          if (in_r.op == plct_pkg::OP_TOGGLE) begin
            mem_we                 = 1'b1;
            mem_waddr              = rd_idx_r;
            mem_wdata              = mem_rdata;
            mem_wdata.fav          = !mem_rdata.fav;
            res_nxt.d.out_favorite = !mem_rdata.fav;
          end else begin
            res_nxt.d.out_id       = mem_rdata.id;
            res_nxt.d.out_type     = mem_rdata.ntype;
            res_nxt.d.out_rssi     = mem_rdata.rssi;
            res_nxt.d.out_snr      = mem_rdata.snr;
            res_nxt.d.out_time     = mem_rdata.htime;
            res_nxt.d.out_favorite = mem_rdata.fav;
          end
        end
      end

      // List: one match held back so the final one can carry last
      S_LIST: begin
        if (list_match && !list_stall) begin
          if (pend_vld_r) begin
            out_nxt               = plct_pkg::mk_res(plct_pkg::ST_OK, 5'(pend_idx_r), 1'b0);
            out_nxt.d.match_count = cnt_r;
            out_vld_nxt           = 1'b1;
          end
          pend_idx_nxt = rd_idx_r;
          pend_vld_nxt = 1'b1;
          cnt_nxt      = cnt_inc;
          if (cnt_inc == limit_r) begin
            rd_vld_nxt            = 1'b0;
            state_nxt             = S_EMIT;
            res_nxt               = plct_pkg::mk_res(plct_pkg::ST_OK, 5'(rd_idx_r), 1'b1);
            res_nxt.d.match_count = cnt_inc;
          end
        end else if (scan_done) begin
          state_nxt = S_EMIT;
          if (pend_vld_r) begin
            res_nxt               = plct_pkg::mk_res(plct_pkg::ST_OK, 5'(pend_idx_r), 1'b1);
            res_nxt.d.match_count = cnt_r;
          end else begin
            res_nxt               = plct_pkg::mk_res(plct_pkg::ST_OK, 5'd0, 1'b1);
          end
        end
      end

      // Final result into the output register
      S_EMIT: begin
        if (!out_busy) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      rd_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      best_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      rd_vld_r   <= rd_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      best_vld_r <= best_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    iss_r      <= iss_nxt;
    end_r      <= end_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_t_r   <= best_t_nxt;
    best_idx_r <= best_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    cnt_r      <= cnt_nxt;
    limit_r    <= limit_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  // Checks
  `PLCT_ASSERT_IMP(a_fill_bound, 1'b1, 32'(fill_r) <= 32'(TABLE_DEPTH))
  `PLCT_ASSERT_NXT(a_accept_busy, in_tvalid && in_tready, state_r != S_IDLE)
  `PLCT_ASSERT_IMP(a_write_in_scan, mem_we, state_r == S_LOOK || state_r == S_OLD || state_r == S_SHIFT || state_r == S_SLOT)
  `PLCT_ASSERT_NXT(a_stall_holds, list_stall, rd_vld_r && $stable(rd_idx_r))

endmodule

### rtl/core/pinned_lru_contact_table.sv
// Top level of the contact table: stream ports, sequencer and entry memory.
// Depends on plct_pkg, plct_mem and plct_ctrl.
`timescale 1ns / 1ps

// Contact table of TABLE_DEPTH node entries kept in one single-port-write,
// registered-read memory; whether an entry is in use follows from the fill
// count, so no clearing pass runs after reset. One transaction is taken at a
// time. Scans read one entry per cycle from the memory read port, unless a
// list scan is held by output back-pressure: find, update and append scan
// the filled entries, a full-table replacement then every entry, remove
// those after the slot, toggle and read one, list the filled ones. A finished
// result waits in the output register while the next transaction is taken.
module pinned_lru_contact_table #(
  parameter int TABLE_DEPTH = plct_pkg::TABLE_DEPTH_DEF,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op, node_id, node_type, rssi_in, snr_in, heard_time, slot, max_count
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, result_slot, out_id, out_type, out_rssi, out_snr, out_time,
  // out_favorite, match_count
  output logic [103:0] out_tdata,
  output logic         out_tlast
);

  plct_pkg::res_t  res;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  plct_pkg::ent_t  mem_wdata;
  logic            mem_re;
  logic [IW-1:0]   mem_raddr;
  plct_pkg::ent_t  mem_rdata;

  plct_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (plct_pkg::in_item_t'(in_tdata)),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  plct_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_tdata = res.d;
  assign out_tlast = res.last;

endmodule

### dv/pinned_lru_contact_table_test.sv
// Self-checking bench for the pinned LRU contact table: random and directed
// table operations, results checked against a behavioral table kept here.
// Depends on plct_pkg and pinned_lru_contact_table.
`timescale 1ns / 1ps

module pinned_lru_contact_table_test;

  localparam int DEPTH = plct_pkg::TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 600000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         out_tlast;

  pinned_lru_contact_table i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #6 clk = ~clk;

  // Shadow table
  plct_pkg::ent_t tbl [DEPTH];
  logic           tbl_act [DEPTH];
  int unsigned    fill;

  plct_pkg::in_item_t pending_ops [$];
  plct_pkg::res_t     expected_res [$];
  int          mismatches = 0;
  int unsigned cycle = 0;
  bit          src_idle_ok = 1'b1;
  bit          sink_idle_ok = 1'b1;
  bit          sink_hold = 1'b0;
  bit          src_pause = 1'b0;
  bit          in_acc = 1'b0;

  function automatic int find_id(logic [31:0] id);
    for (int i = 0; i < fill; i++)
      if (tbl_act[i] && tbl[i].id == id) return i;
    return -1;
  endfunction

  // Work out the results of one accepted operation and update the table
  task automatic apply_op(plct_pkg::in_item_t it);
    int f;
    int best;
    int n;
    int lim;
    logic [31:0] best_t;
    plct_pkg::res_t r;
    case (it.op)
      plct_pkg::OP_UPSERT: begin
        f = find_id(it.node_id);
        if (f >= 0) begin
          tbl[f] = plct_pkg::mk_ent(it, tbl[f].fav);
          expected_res.push_back(plct_pkg::mk_res(plct_pkg::ST_OK, f[4:0], 1'b1));
        end else begin
          if (fill >= DEPTH) begin
            best = -1;
            best_t = plct_pkg::HTIME_CEIL;
            for (int i = 0; i < DEPTH; i++)
              if (!tbl[i].fav && tbl[i].htime < best_t) begin
                best_t = tbl[i].htime;
                best = i;
              end
          end else begin
            best = fill;
            fill++;
          end
          if (best < 0) begin
            expected_res.push_back(plct_pkg::mk_res(plct_pkg::ST_ALL_FAV, 5'd0, 1'b1));
          end else begin
            tbl[best] = plct_pkg::mk_ent(it, 1'b0);
            tbl_act[best] = 1'b1;
            expected_res.push_back(plct_pkg::mk_res(plct_pkg::ST_OK, best[4:0], 1'b1));
          end
        end
      end
      plct_pkg::OP_FIND: begin
        f = find_id(it.node_id);
        if (f < 0) expected_res.push_back(plct_pkg::mk_res(plct_pkg::ST_MISS, 5'd0, 1'b1));
        else expected_res.push_back(plct_pkg::mk_res(plct_pkg::ST_OK, f[4:0], 1'b1));
      end
      plct_pkg::OP_REMOVE: begin
        if (it.slot >= fill) begin
          expected_res.push_back(plct_pkg::mk_res(plct_pkg::ST_MISS, 5'd0, 1'b1));
        end else begin
          for (int i = it.slot; i + 1 < fill; i++) begin
            tbl[i] = tbl[i+1];
            tbl_act[i] = tbl_act[i+1];
          end
          tbl[fill-1] = '0;
          tbl_act[fill-1] = 1'b0;
          fill--;
          expected_res.push_back(plct_pkg::mk_res(plct_pkg::ST_OK, it.slot, 1'b1));
        end
      end
      plct_pkg::OP_TOGGLE, plct_pkg::OP_READ: begin
        if (it.slot >= fill || !tbl_act[it.slot]) begin
          expected_res.push_back(plct_pkg::mk_res(plct_pkg::ST_MISS, 5'd0, 1'b1));
        end else begin
          if (it.op == plct_pkg::OP_TOGGLE) tbl[it.slot].fav = ~tbl[it.slot].fav;
          r = plct_pkg::mk_res(plct_pkg::ST_OK, it.slot, 1'b1);
          r.d.out_favorite = tbl[it.slot].fav;
          if (it.op == plct_pkg::OP_READ) begin
            r.d.out_id   = tbl[it.slot].id;
            r.d.out_type = tbl[it.slot].ntype;
            r.d.out_rssi = tbl[it.slot].rssi;
            r.d.out_snr  = tbl[it.slot].snr;
            r.d.out_time = tbl[it.slot].htime;
          end
          expected_res.push_back(r);
        end
      end
      plct_pkg::OP_LIST: begin
        lim = (it.max_count > plct_pkg::LIST_CAP) ? int'(plct_pkg::LIST_CAP)
                                                  : int'(it.max_count);
        n = 0;
        for (int i = 0; i < fill && n < lim; i++)
          if (tbl_act[i] && tbl[i].ntype == it.node_type) begin
            n++;
            r = plct_pkg::mk_res(plct_pkg::ST_OK, i[4:0], 1'b0);
            r.d.match_count = n[5:0];
            expected_res.push_back(r);
          end
        if (n == 0) expected_res.push_back(plct_pkg::mk_res(plct_pkg::ST_OK, 5'd0, 1'b1));
        else expected_res[$].last = 1'b1;
      end
      default: expected_res.push_back(plct_pkg::mk_res(plct_pkg::ST_MISS, 5'd0, 1'b1));
    endcase
  endtask

  // Random operation; ids drawn from a small pool so hits are common
  function automatic plct_pkg::in_item_t rand_op(int unsigned op_hi);
    plct_pkg::in_item_t it;
    it.pad        = '0;
    it.op         = 3'($urandom_range(op_hi, 0));
    it.node_id    = ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(47, 0);
    it.node_type  = 8'(($urandom_range(7, 0) == 0) ? $urandom : $urandom_range(3, 0));
    it.rssi_in    = 8'($urandom);
    it.snr_in     = 8'($urandom);
    it.heard_time = ($urandom_range(9, 0) == 0) ? plct_pkg::HTIME_CEIL :
                    ($urandom_range(1, 0) ? $urandom_range(1000, 0) : $urandom);
    it.slot       = 5'($urandom);
    it.max_count  = 6'(($urandom_range(2, 0) == 0) ? $urandom : $urandom_range(33, 0));
    return it;
  endfunction

  function automatic plct_pkg::in_item_t mk_op(plct_pkg::op_t op, logic [31:0] id,
                                               logic [7:0] ty, logic [31:0] t,
                                               logic [4:0] s, logic [5:0] mc);
    plct_pkg::in_item_t it;
    it = '0;
    it.op = op; it.node_id = id; it.node_type = ty; it.heard_time = t;
    it.slot = s; it.max_count = mc;
    it.rssi_in = 8'sh80; it.snr_in = 8'sh7F;
    return it;
  endfunction

  // Stimulus
  initial begin
    plct_pkg::in_item_t it;
    for (int i = 0; i < DEPTH; i++) begin
      tbl[i] = '0;
      tbl_act[i] = 1'b0;
    end
    fill = 0;
    // Directed: extremes, every op, misses, unknown ops, full table cases
    pending_ops.push_back(mk_op(plct_pkg::OP_READ, 32'd0, 8'd0, 32'd0, 5'd0, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_REMOVE, 32'd0, 8'd0, 32'd0, 5'd31, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_UPSERT, 32'hFFFF_FFFF, 8'hFF,
                                plct_pkg::HTIME_CEIL, 5'd0, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_UPSERT, 32'd0, 8'hFF, 32'd0, 5'd0, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_FIND, 32'hFFFF_FFFF, 8'd0, 32'd0, 5'd0, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_FIND, 32'h1234_5678, 8'd0, 32'd0, 5'd0, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_TOGGLE, 32'd0, 8'd0, 32'd0, 5'd1, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_READ, 32'd0, 8'd0, 32'd0, 5'd1, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_TOGGLE, 32'd0, 8'd0, 32'd0, 5'd31, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_LIST, 32'd0, 8'hFF, 32'd0, 5'd0, 6'd63));
    pending_ops.push_back(mk_op(plct_pkg::OP_LIST, 32'd0, 8'hFF, 32'd0, 5'd0, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_LIST, 32'd0, 8'h7, 32'd0, 5'd0, 6'd5));
    it = mk_op(plct_pkg::OP_UPSERT, 32'd0, 8'd0, 32'd0, 5'd0, 6'd0);
    it.op = 3'd6;
    pending_ops.push_back(it);
    it.op = 3'd7;
    pending_ops.push_back(it);
    pending_ops.push_back(mk_op(plct_pkg::OP_REMOVE, 32'd0, 8'd0, 32'd0, 5'd0, 6'd0));
    // Fill the table, toggle every favorite flag, then try a replacement
    for (int i = 0; i < DEPTH; i++)
      pending_ops.push_back(mk_op(plct_pkg::OP_UPSERT, 100 + i, 8'd1, 5 + i, 5'd0, 6'd0));
    for (int i = 0; i < DEPTH; i++)
      pending_ops.push_back(mk_op(plct_pkg::OP_TOGGLE, 32'd0, 8'd0, 32'd0, i[4:0], 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_UPSERT, 32'd999, 8'd2, 32'd7, 5'd0, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_LIST, 32'd0, 8'd1, 32'd0, 5'd0, 6'd40));
    pending_ops.push_back(mk_op(plct_pkg::OP_TOGGLE, 32'd0, 8'd0, 32'd0, 5'd3, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_TOGGLE, 32'd0, 8'd0, 32'd0, 5'd9, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_UPSERT, 32'd998, 8'd2, 32'd7, 5'd0, 6'd0));
    pending_ops.push_back(mk_op(plct_pkg::OP_READ, 32'd0, 8'd0, 32'd0, 5'd31, 6'd0));
    // Random: mostly table ops, some unknown codes
    for (int i = 0; i < 75; i++)
      pending_ops.push_back(rand_op(($urandom_range(15, 0) == 0) ? 7 : 5));
  end

  // Driver: a new transaction once the previous one was taken
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_acc) && pending_ops.size() > 0 && !src_pause
        && !(src_idle_ok && $urandom_range(99, 0) < 25)) begin
      in_tdata  <= pending_ops.pop_front();
      in_tvalid <= 1'b1;
    end else if (rst_n && in_acc) begin
      in_tvalid <= 1'b0;
    end
  end

  // Predict on accepted input
  always @(posedge clk) begin
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) apply_op(plct_pkg::in_item_t'(in_tdata));
  end

  // Result side ready
  always @(negedge clk) begin
    out_tready <= rst_n && !sink_hold && !(sink_idle_ok && $urandom_range(99, 0) < 25);
  end

  // Monitor
  always @(posedge clk) begin
    plct_pkg::res_t got;
    plct_pkg::res_t want;
    cycle <= cycle + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.last = out_tlast;
      got.d = plct_pkg::out_item_t'(out_tdata);
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h last %b", out_tdata, out_tlast);
      end else begin
        want = expected_res.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h last %b, got %h last %b",
                     want.d, want.last, got.d, got.last);
        end
      end
    end
  end

  // Sequencing: reset, pressure phases, end of run
  initial begin
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    // Long receiver hold while the sender keeps offering
    repeat (30) @(posedge clk);
    sink_hold = 1'b1;
    repeat (300) @(posedge clk);
    sink_hold = 1'b0;
    // Sender pause until all results are in
    wait (pending_ops.size() < 140);
    src_pause = 1'b1;
    wait (expected_res.size() == 0 && !in_tvalid);
    src_pause = 1'b0;
    // Stretch without idling
    wait (pending_ops.size() < 100);
    src_idle_ok = 1'b0;
    sink_idle_ok = 1'b0;
    wait (pending_ops.size() < 50);
    src_idle_ok = 1'b1;
    sink_idle_ok = 1'b1;
    wait (pending_ops.size() == 0 && !in_tvalid && expected_res.size() == 0);
    n = 0;
    while (n < 200 && expected_res.size() == 0) begin
      @(posedge clk);
      n++;
    end
    wait (expected_res.size() == 0);
    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Timeout
  always @(posedge clk) begin
    if (cycle >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
